// File: rtl/qpsk_pkg.sv
// Shared types, constants and the quarter-wave sine table of the QPSK modulator.
`default_nettype none

package qpsk_pkg;

  localparam int unsigned SAMPLES_PER_SYMBOL = 18;
  localparam int unsigned IDX_W       = $clog2(SAMPLES_PER_SYMBOL);
  localparam int unsigned PHASE_STEPS = 72;
  localparam int unsigned PHASE_W     = $clog2(PHASE_STEPS + 4);
  localparam int unsigned QUARTER     = PHASE_STEPS / 4;
  localparam int unsigned ROM_ADDR_W  = $clog2(QUARTER + 1);
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CNT_W       = 31;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(SAMPLES_PER_SYMBOL - 1);
  localparam logic [PHASE_W-1:0] PHASE_INC  = PHASE_W'(PHASE_STEPS / SAMPLES_PER_SYMBOL);
  localparam logic [PHASE_W-1:0] PHASE_WRAP = PHASE_W'(PHASE_STEPS) - PHASE_INC;
  localparam logic [PHASE_W-1:0] PHASE_Q1   = PHASE_W'(QUARTER);
  localparam logic [PHASE_W-1:0] PHASE_Q2   = PHASE_W'(2 * QUARTER);
  localparam logic [PHASE_W-1:0] PHASE_Q3   = PHASE_W'(3 * QUARTER);
  localparam logic [PHASE_W-1:0] PHASE_FULL = PHASE_W'(PHASE_STEPS);

  // Start phase 9*k for each bit pair.
  localparam logic [PHASE_W-1:0] PHASE_00 = PHASE_W'(27);
  localparam logic [PHASE_W-1:0] PHASE_01 = PHASE_W'(9);
  localparam logic [PHASE_W-1:0] PHASE_10 = PHASE_W'(45);
  localparam logic [PHASE_W-1:0] PHASE_11 = PHASE_W'(63);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SAMPLE = 2'd0,
    STATUS_END    = 2'd1,
    STATUS_ERROR  = 2'd2
  } status_e;

  // One request from the sequencer to the output stage.
  typedef struct packed {
    status_e                 status;
    logic                    last;
    logic                    neg;
    logic [ROM_ADDR_W-1:0]   addr;
    logic [CNT_W-1:0]        count;
  } qpsk_req_t;

  // Magnitude of 0x7F000000 * sin(n * 5 degrees), truncated, n = 0..18.
  function automatic logic [SAMPLE_W-1:0] quarter_wave(input logic [ROM_ADDR_W-1:0] addr);
    logic [SAMPLE_W-1:0] mag;
    unique case (addr)
      5'd0:  mag = 32'd0;
      5'd1:  mag = 32'd185703301;
      5'd2:  mag = 32'd369993289;
      5'd3:  mag = 32'd551467404;
      5'd4:  mag = 32'd728744519;
      5'd5:  mag = 32'd900475448;
      5'd6:  mag = 32'd1065353216;
      5'd7:  mag = 32'd1222123002;
      5'd8:  mag = 32'd1369591694;
      5'd9:  mag = 32'd1506636966;
      5'd10: mag = 32'd1632215822;
      5'd11: mag = 32'd1745372529;
      5'd12: mag = 32'd1845245898;
      5'd13: mag = 32'd1931075831;
      5'd14: mag = 32'd2002209111;
      5'd15: mag = 32'd2058104370;
      5'd16: mag = 32'd2098336213;
      5'd17: mag = 32'd2122598450;
      5'd18: mag = 32'd2130706432;
      default: mag = 32'd0;
    endcase
    return mag;
  endfunction

endpackage

`default_nettype wire

// File: rtl/qpsk_seq.sv
// Request decoder, symbol counter and per-sample phase sequencer.
`default_nettype none

module qpsk_seq
  import qpsk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CHAR_W-1:0] first_char_i,
  input  wire logic              first_is_end_i,
  input  wire logic [CHAR_W-1:0] second_char_i,
  input  wire logic              second_is_end_i,
  output logic                   req_valid_o,
  input  wire logic              req_ready_i,
  output qpsk_req_t              req_o
);

  logic               busy_q, busy_d;
  status_e            status_q, status_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   snap_q, snap_d;

  logic               first_ok, second_ok, pair_ok, is_end;
  logic [PHASE_W-1:0] start_phase;
  logic               advance, item_done, accept;
  logic [PHASE_W-1:0] fold_addr;
  logic               fold_neg;

  assign first_ok  = (first_char_i == CHAR_ZERO) || (first_char_i == CHAR_ONE);
  assign second_ok = (second_char_i == CHAR_ZERO) || (second_char_i == CHAR_ONE);
  assign pair_ok   = !first_is_end_i && !second_is_end_i && first_ok && second_ok;
  assign is_end    = (first_is_end_i && second_is_end_i) ||
                     (!first_is_end_i && (first_char_i == CHAR_NEWLINE) && second_is_end_i);

  always_comb begin
    if (first_char_i == CHAR_ZERO) begin
      start_phase = (second_char_i == CHAR_ZERO) ? PHASE_00 : PHASE_01;
    end else begin
      start_phase = (second_char_i == CHAR_ZERO) ? PHASE_10 : PHASE_11;
    end
  end

  assign advance    = busy_q && req_ready_i;
  assign item_done  = (status_q != STATUS_SAMPLE) || (idx_q == LAST_IDX);
  assign in_ready_o = !busy_q || (req_ready_i && item_done);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d   = busy_q;
    status_d = status_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    count_d  = count_q;
    snap_d   = snap_q;
    if (accept) begin
      busy_d  = 1'b1;
      phase_d = start_phase;
      idx_d   = '0;
      snap_d  = count_q;
      if (pair_ok) begin
        status_d = STATUS_SAMPLE;
        count_d  = count_q + CNT_W'(1);
      end else if (is_end) begin
        status_d = STATUS_END;
      end else begin
        status_d = STATUS_ERROR;
      end
    end else if (advance && item_done) begin
      busy_d = 1'b0;
    end else if (advance) begin
      idx_d   = idx_q + IDX_W'(1);
      phase_d = (phase_q >= PHASE_WRAP) ? (phase_q - PHASE_WRAP) : (phase_q + PHASE_INC);
    end
  end

  // Fold the full-wave phase onto the quarter-wave table.
  always_comb begin
    if (phase_q <= PHASE_Q1) begin
      fold_addr = phase_q;
      fold_neg  = 1'b0;
    end else if (phase_q <= PHASE_Q2) begin
      fold_addr = PHASE_Q2 - phase_q;
      fold_neg  = 1'b0;
    end else if (phase_q <= PHASE_Q3) begin
      fold_addr = phase_q - PHASE_Q2;
      fold_neg  = 1'b1;
    end else begin
      fold_addr = PHASE_FULL - phase_q;
      fold_neg  = 1'b1;
    end
  end

  assign req_valid_o  = busy_q;
  assign req_o.status = status_q;
  assign req_o.last   = item_done;
  assign req_o.neg    = fold_neg;
  assign req_o.addr   = fold_addr[ROM_ADDR_W-1:0];
  assign req_o.count  = (status_q == STATUS_SAMPLE) ? '0 : snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    phase_q  <= phase_d;
    idx_q    <= idx_d;
    snap_q   <= snap_d;
  end

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_ready_i |=> $stable(phase_q) && $stable(idx_q) && busy_q)
    else $error("sequencer moved while stalled");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= LAST_IDX) && (phase_q < PHASE_FULL))
    else $error("sample index or phase out of range");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (status_q != STATUS_SAMPLE) |-> req_o.last)
    else $error("status request not marked last");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pair_ok |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("symbol counter missed a valid pair");
`endif

endmodule

`default_nettype wire

// File: rtl/qpsk_out.sv
// Registered sine table read and output register stage.
`default_nettype none

module qpsk_out
  import qpsk_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire qpsk_req_t     req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [SAMPLE_W-1:0] sample_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [CNT_W-1:0]   symbol_total_o,
  output logic               last_o
);

  logic                valid_q, valid_d;
  logic [SAMPLE_W-1:0] rom_q;
  status_e             status_q;
  logic                last_q, neg_q;
  logic [CNT_W-1:0]    count_q;
  logic                load;

  assign req_ready_o = !valid_q || out_ready_i;
  assign load        = req_valid_i && req_ready_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Registered table read; payload moves only on a load.
  always_ff @(posedge clk_i) begin
    if (load) begin
      rom_q    <= quarter_wave(req_i.addr);
      status_q <= req_i.status;
      last_q   <= req_i.last;
      neg_q    <= req_i.neg;
      count_q  <= req_i.count;
    end
  end

  assign out_valid_o    = valid_q;
  assign status_o       = status_q;
  assign last_o         = last_q;
  assign symbol_total_o = count_q;
  assign sample_o       = (status_q != STATUS_SAMPLE) ? '0 : (neg_q ? (-rom_q) : rom_q);

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(rom_q) && $stable(count_q))
    else $error("output overwritten while stalled");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_o != STATUS_SAMPLE) |-> (sample_o == '0) && last_o)
    else $error("status result carries a sample");

  a_sample_no_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_o == STATUS_SAMPLE) |-> (symbol_total_o == '0))
    else $error("sample result carries a count");
`endif

endmodule

`default_nettype wire

// File: rtl/qpsk_symbol_modulator_core.sv
// Top level of the QPSK symbol modulator: sequencer plus sine table output stage.
`default_nettype none

// Each request carries two ASCII characters with end-of-input flags. A pair of
// '0'/'1' characters with no end flag selects a carrier phase k*pi/4 (pairs
// 00, 01, 10, 11 give k = 3, 1, 5, 7) and produces 18 signed samples of
// 0x7F000000*sin(2*pi*i/18 + k*pi/4), one result per cycle, with last set on
// the eighteenth; the symbol counter advances (modulo 2^31) when the pair is
// taken. Two end flags, or an unflagged newline followed by an end flag,
// produce one end result (status 1) and any other pair one error result
// (status 2); both carry the symbol count in symbol_total and a zero sample.
// A status request issues a single table read; the next request is taken in
// the same cycle that the last table read of the current one issues, so
// symbols stream without gaps. The first result is presented once the request
// has passed the sequencer's phase register and the output register. The sine
// table holds a quarter wave of 19 entries behind a registered read port; the
// sequencer folds the running phase onto it and the output stage restores the
// sign. Backpressure on the output stalls the sequencer in place.
module qpsk_symbol_modulator_core
  import qpsk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CHAR_W-1:0]  first_char_i,
  input  wire logic               first_is_end_i,
  input  wire logic [CHAR_W-1:0]  second_char_i,
  input  wire logic               second_is_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [SAMPLE_W-1:0]     sample_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [CNT_W-1:0]        symbol_total_o,
  output logic                    last_o
);

  // Request path from the sequencer to the table read stage.
  logic      req_valid;
  logic      req_ready;
  qpsk_req_t req;

  qpsk_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .first_char_i    (first_char_i),
    .first_is_end_i  (first_is_end_i),
    .second_char_i   (second_char_i),
    .second_is_end_i (second_is_end_i),
    .req_valid_o     (req_valid),
    .req_ready_i     (req_ready),
    .req_o           (req)
  );

  qpsk_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_i          (req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_o       (sample_o),
    .status_o       (status_o),
    .symbol_total_o (symbol_total_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// File: tb/qpsk_symbol_modulator_core_tb.sv
// Self-checking testbench for the QPSK symbol modulator core with a scoreboard.
`default_nettype none

// Requests go in over a valid/ready channel. Results come out over a second
// one. Both sides idle at random, except for one stretch of back-to-back
// traffic in the middle of the random phase. Every accepted request is
// expanded into the results it must produce, by a local model or from the
// directed table. Those go into a FIFO, and each accepted result is checked
// field by field against the oldest entry.
//
// Inputs are driven with nonblocking assignments on the rising edge.
// Handshakes are sampled on the falling edge, when everything has settled,
// so a request or result seen there is taken by the block on the next
// rising edge.
module qpsk_symbol_modulator_core_tb;
  import qpsk_pkg::*;

  // Carrier geometry as the modulator defines it: 72 phase steps of
  // 5 degrees per period, with one quarter wave held in a table.
  localparam int unsigned CARRIER_STEPS = 72;
  localparam int unsigned QUARTER_STEPS = CARRIER_STEPS / 4;
  localparam int unsigned STEP_PER_SAMPLE = CARRIER_STEPS / SAMPLES_PER_SYMBOL;
  localparam int unsigned PAIR_STEP = 9;
  localparam int unsigned RANDOM_REQUESTS = 248;
  // Limit on a stretch with no handshake on either side; a correct run
  // stays well inside it, so this limit has a wide margin.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles to watch for stray results once the FIFO has drained.
  localparam int unsigned DRAIN_CYCLES = 20;

  // One result as the block presents it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    status_e                    status;
    logic [CNT_W-1:0]           total;
    logic                       last;
  } result_t;

  // One row of the directed table. Where has_result is set, the row's
  // single status result is typed in below. Otherwise the model works it out.
  typedef struct packed {
    logic [CHAR_W-1:0] first_char;
    logic              first_end;
    logic [CHAR_W-1:0] second_char;
    logic              second_end;
    logic              has_result;
    status_e           status;
    logic [CNT_W-1:0]  total;
  } stim_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic [CHAR_W-1:0]   first_char_i    = '0;
  logic                first_is_end_i  = 1'b0;
  logic [CHAR_W-1:0]   second_char_i   = '0;
  logic                second_is_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [SAMPLE_W-1:0] sample_o;
  logic [STATUS_W-1:0] status_o;
  logic [CNT_W-1:0]    symbol_total_o;
  logic                last_o;

  // Magnitude of 0x7F000000 * sin(n * 5 degrees), truncated, for n = 0..18.
  logic [SAMPLE_W-1:0] sine_quarter [0:18] = '{
    32'd0,          32'd185703301,  32'd369993289,  32'd551467404,
    32'd728744519,  32'd900475448,  32'd1065353216, 32'd1222123002,
    32'd1369591694, 32'd1506636966, 32'd1632215822, 32'd1745372529,
    32'd1845245898, 32'd1931075831, 32'd2002209111, 32'd2058104370,
    32'd2098336213, 32'd2122598450, 32'd2130706432
  };

  // The directed table. It opens with status requests while the symbol
  // count is still zero. Then come all four bit pairs, then status requests
  // at count four, then two more symbols and one last error at count six.
  stim_row_t directed_rows [0:21] = '{
    // Two end flags.
    '{8'h00, 1'b1, 8'h00, 1'b1, 1'b1, STATUS_END,    31'd0},
    // A newline that is not flagged, followed by an end flag.
    '{8'h0A, 1'b0, 8'h00, 1'b1, 1'b1, STATUS_END,    31'd0},
    // A newline that is itself flagged still ends the input when both flags are set.
    '{8'h0A, 1'b1, 8'hFF, 1'b1, 1'b1, STATUS_END,    31'd0},
    // A newline with no end flag after it is an error.
    '{8'h0A, 1'b0, 8'h0A, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    // A valid-looking pair with only one of its flags set is an error.
    '{8'h30, 1'b1, 8'h30, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    '{8'h31, 1'b0, 8'h31, 1'b1, 1'b1, STATUS_ERROR,  31'd0},
    // Extreme character values.
    '{8'hFF, 1'b0, 8'hFF, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    // Characters just outside '0'..'1', and a '0' with its top bit set.
    '{8'h2F, 1'b0, 8'h30, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    '{8'h30, 1'b0, 8'h32, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    '{8'hB0, 1'b0, 8'h31, 1'b0, 1'b1, STATUS_ERROR,  31'd0},
    // The four bit pairs.
    '{8'h30, 1'b0, 8'h30, 1'b0, 1'b0, STATUS_SAMPLE, 31'd0},
    '{8'h30, 1'b0, 8'h31, 1'b0, 1'b0, STATUS_SAMPLE, 31'd0},
    '{8'h31, 1'b0, 8'h30, 1'b0, 1'b0, STATUS_SAMPLE, 31'd0},
    '{8'h31, 1'b0, 8'h31, 1'b0, 1'b0, STATUS_SAMPLE, 31'd0},
    // Status results now carry the four symbols counted so far.
    '{8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, STATUS_END,    31'd4},
    '{8'h30, 1'b1, 8'h31, 1'b1, 1'b1, STATUS_END,    31'd4},
    '{8'h31, 1'b1, 8'h31, 1'b0, 1'b1, STATUS_ERROR,  31'd4},
    '{8'h0A, 1'b0, 8'h31, 1'b0, 1'b1, STATUS_ERROR,  31'd4},
    '{8'h31, 1'b0, 8'h30, 1'b0, 1'b0, STATUS_SAMPLE, 31'd0},
    '{8'h30, 1'b0, 8'h30, 1'b0, 1'b0, STATUS_SAMPLE, 31'd0},
    // A newline with its top bit set is not a newline.
    '{8'h8A, 1'b0, 8'h00, 1'b1, 1'b1, STATUS_ERROR,  31'd6}
  };

  result_t          pending_results [$];
  logic [CNT_W-1:0] symbol_tally = '0;
  int unsigned      error_count  = 0;
  int unsigned      quiet_cycles = 0;
  // Set during one window of the random phase to switch off idling on both sides.
  logic             steady       = 1'b0;

  qpsk_symbol_modulator_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signed carrier sample at phase step n, unfolded from the quarter wave.
  function automatic logic signed [SAMPLE_W-1:0] carrier_sample(input int unsigned n);
    int unsigned         p;
    logic [SAMPLE_W-1:0] mag;
    logic                neg;
    p   = n % CARRIER_STEPS;
    neg = 1'b0;
    if (p <= QUARTER_STEPS) begin
      mag = sine_quarter[p];
    end else if (p <= 2 * QUARTER_STEPS) begin
      mag = sine_quarter[2 * QUARTER_STEPS - p];
    end else if (p <= 3 * QUARTER_STEPS) begin
      mag = sine_quarter[p - 2 * QUARTER_STEPS];
      neg = 1'b1;
    end else begin
      mag = sine_quarter[CARRIER_STEPS - p];
      neg = 1'b1;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Queues the results that one request must produce and updates the symbol
  // count.
  task automatic predict_request(input logic [CHAR_W-1:0] c1, input logic e1,
                                 input logic [CHAR_W-1:0] c2, input logic e2);
    int unsigned k;
    int unsigned i;
    result_t     r;
    if (!e1 && !e2 && (c1 == CHAR_ZERO || c1 == CHAR_ONE) &&
        (c2 == CHAR_ZERO || c2 == CHAR_ONE)) begin
      // Pairs 00, 01, 10 and 11 start at phase k*pi/4 with k = 3, 1, 5, 7.
      if (c1 == CHAR_ZERO) begin
        k = (c2 == CHAR_ZERO) ? 3 : 1;
      end else begin
        k = (c2 == CHAR_ZERO) ? 5 : 7;
      end
      for (i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
        r.sample = carrier_sample(STEP_PER_SAMPLE * i + PAIR_STEP * k);
        r.status = STATUS_SAMPLE;
        r.total  = '0;
        r.last   = (i == SAMPLES_PER_SYMBOL - 1);
        pending_results.push_back(r);
      end
      symbol_tally = symbol_tally + 1'b1;
    end else begin
      r.sample = '0;
      if ((e1 && e2) || (!e1 && c1 == CHAR_NEWLINE && e2)) begin
        r.status = STATUS_END;
      end else begin
        r.status = STATUS_ERROR;
      end
      r.total = symbol_tally;
      r.last  = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // Presents one request after a random number of idle cycles and returns on
  // the rising edge that takes it. The results it must produce are queued at
  // the falling edge just before that, once the handshake is certain. It is
  // always entered right after a rising edge, so valid is never lowered and
  // raised again in the same step.
  task automatic send_request(input logic [CHAR_W-1:0] c1, input logic e1,
                              input logic [CHAR_W-1:0] c2, input logic e2,
                              input logic has_result, input result_t fixed);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    first_char_i    <= c1;
    first_is_end_i  <= e1;
    second_char_i   <= c2;
    second_is_end_i <= e2;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    if (has_result) begin
      pending_results.push_back(fixed);
    end else begin
      predict_request(c1, e1, c2, e2);
    end
    @(posedge clk_i);
  endtask

  // The receiver stalls at random with a chance of 18 in 100, except in the
  // steady window.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 18);
  end

  // Check each result as it is accepted against the oldest expectation.
  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: sample %0d status %0d total %0d last %0b",
               $signed(sample_o), status_o, symbol_total_o, last_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if ($signed(sample_o) !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, $signed(sample_o));
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (symbol_total_o !== want.total) begin
          $error("symbol_total: expected %0d, got %0d", want.total, symbol_total_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // The watchdog counts the cycles in which neither side moves anything.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned       n;
    int unsigned       roll;
    int unsigned       pick;
    logic [CHAR_W-1:0] c1;
    logic [CHAR_W-1:0] c2;
    logic              e1;
    logic              e2;
    result_t           fixed;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Rows with a typed result expect one status result with a
    // zero sample and last set.
    for (n = 0; n < $size(directed_rows); n++) begin
      fixed.sample = '0;
      fixed.status = directed_rows[n].status;
      fixed.total  = directed_rows[n].total;
      fixed.last   = 1'b1;
      send_request(directed_rows[n].first_char, directed_rows[n].first_end,
                   directed_rows[n].second_char, directed_rows[n].second_end,
                   directed_rows[n].has_result, fixed);
    end

    // Random part. Most requests are well-formed symbols. The rest are end
    // markers, near misses of a valid pair, and plain noise.
    fixed = '0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      steady <= (n >= 100 && n < 160);
      roll = $urandom_range(99);
      pick = $urandom_range(3);
      c1   = CHAR_ZERO | CHAR_W'($urandom_range(1));
      c2   = CHAR_ZERO | CHAR_W'($urandom_range(1));
      e1   = 1'b0;
      e2   = 1'b0;
      if (roll < 60) begin
        // Well-formed symbol: the defaults stand.
      end else if (roll < 70) begin
        // End of input, either through two flags or through a newline.
        e2 = 1'b1;
        if (pick[0]) begin
          e1 = 1'b1;
          c1 = CHAR_W'($urandom);
          c2 = CHAR_W'($urandom);
        end else begin
          c1 = CHAR_NEWLINE;
          c2 = CHAR_W'($urandom);
        end
      end else if (roll < 85) begin
        // Near misses of a valid pair; a flip of bit 0 still gives a valid pair.
        case (pick)
          0: begin
            e1 = 1'($urandom_range(1));
            e2 = !e1;
          end
          1: begin
            c1 = CHAR_NEWLINE;
            c2 = CHAR_W'($urandom);
          end
          2: begin
            if ($urandom_range(1)) begin
              c1 = c1 ^ (CHAR_W'(1) << $urandom_range(CHAR_W - 1));
            end else begin
              c2 = c2 ^ (CHAR_W'(1) << $urandom_range(CHAR_W - 1));
            end
          end
          default: begin
            c1 = CHAR_NEWLINE;
            e1 = 1'b1;
          end
        endcase
      end else begin
        c1 = CHAR_W'($urandom);
        c2 = CHAR_W'($urandom);
        e1 = 1'($urandom_range(1));
        e2 = 1'($urandom_range(1));
      end
      send_request(c1, e1, c2, e2, 1'b0, fixed);
    end
    in_valid_i <= 1'b0;
    steady     <= 1'b0;

    // Wait for the FIFO to drain. Then watch for stray results for a while.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
